// ===== design/bct_pkg.sv =====
package bct_pkg;

   localparam int KEY_W = 32;

   localparam logic KIND_LAN = 1'b0;
   localparam logic KIND_WAN = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  flow_hash;
   } req_type;

   typedef struct packed {
      logic found;
      logic inserted;
      logic bucket_full;
   } rsp_type;

endpackage

// ===== design/bucketed_connection_table.sv =====
// Path: when BUCKETS is a power of two, an accepted word goes through the bucket read,
// then compare and write-back in ST_LOOK; otherwise the bucket index is first reduced
// by a reciprocal multiply in ST_MOD, ST_QUO and ST_REM before the read in ST_READ.
// Items: the single bucket memory port pair serves one item at a time, so a new word is
// taken only once the current result word is loaded; a stalled result word holds the next item back until it is taken.
// Reset: a clearing pass writes every bucket row to zero, one row a cycle, with req_stall
// held high until it ends.
module bucketed_connection_table
   import bct_pkg::*;
#(
   parameter int BUCKETS = 16384,
   parameter int WAYS    = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int  BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int  FW      = $clog2(WAYS + 1);
   localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   // reciprocal of BUCKETS: quotient = (key * (2^KEY_W + M_LO)) >> SH, exact for any key
   localparam int              SH        = KEY_W + $clog2(BUCKETS);
   localparam logic [64:0]     M_FULL    = ((65'd1 << SH) + 65'(BUCKETS) - 65'd1)
                                           / 65'(BUCKETS);
   localparam logic [KEY_W-1:0] M_LO      = M_FULL[KEY_W-1:0];
   localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_LOOK  = 3'd4;
   localparam logic [2:0] ST_QUO   = 3'd5;
   localparam logic [2:0] ST_REM   = 3'd6;

   typedef struct packed {
      logic [FW-1:0]              fill;
      logic [WAYS-1:0][KEY_W-1:0] ent;
   } row_type;

   row_type mem [BUCKETS];

   logic [2:0]         state_ff, state_in;
   logic [BW-1:0]      clr_addr_ff, clr_addr_in;
   logic [BW-1:0]      bucket_ff, bucket_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               kind_ff, kind_in;
   logic [2*KEY_W-1:0] prod_ff, prod_in;
   logic [KEY_W-1:0]   quo_ff, quo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   row_type            rd_row_ff;

   logic              accept;
   logic              out_free;
   logic [2*KEY_W:0]  quo_sum;
   logic              rd_en;
   logic [BW-1:0]     rd_addr;
   logic              wr_en;
   logic [BW-1:0]     wr_addr;
   row_type           wr_row;
   rsp_type           dec;
   logic [WAYS-1:0][KEY_W-1:0] new_ent;
   logic [FW-1:0]     new_fill;

   bct_bucket_match #(.WAYS(WAYS)) u_match (
      .ent      (rd_row_ff.ent),
      .fill     (rd_row_ff.fill),
      .key      (key_ff),
      .kind     (kind_ff),
      .dec      (dec),
      .new_ent  (new_ent),
      .new_fill (new_fill)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign quo_sum = {1'b0, prod_ff} + {1'b0, key_ff, {KEY_W{1'b0}}};

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      bucket_in    = bucket_ff;
      key_in       = key_ff;
      kind_in      = kind_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = req_data.flow_hash[BW-1:0];
      wr_en        = 1'b0;
      wr_addr      = bucket_ff;
      wr_row.fill  = new_fill;
      wr_row.ent   = new_ent;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_row      = '0;
            clr_addr_in = clr_addr_ff + BW'(1);
            if (clr_addr_ff == BW'(BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               key_in    = req_data.flow_hash;
               kind_in   = req_data.kind;
               bucket_in = req_data.flow_hash[BW-1:0];
               if (IS_POW2) begin
                  rd_en    = 1'b1;
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            prod_in  = {{KEY_W{1'b0}}, key_ff} * {{KEY_W{1'b0}}, M_LO};
            state_in = ST_QUO;
         end
         ST_QUO: begin
            // add the implicit top bit of the reciprocal, then drop the fraction
            quo_in   = KEY_W'(quo_sum >> SH);
            state_in = ST_REM;
         end
         ST_REM: begin
            bucket_in = BW'(key_ff - quo_ff * BUCKETS_K);
            state_in  = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = bucket_ff;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            // hold the read row until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dec;
               wr_en        = dec.inserted;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff   <= bucket_in;
      key_ff      <= key_in;
      kind_ff     <= kind_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_row;
      if (rd_en) rd_row_ff <= mem[rd_addr];
   end

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_LOOK))
      else $error("bucket write outside clear or write-back");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_LOOK) |-> (wr_row.fill == rd_row_ff.fill + FW'(1)))
      else $error("insert did not advance the fill count by one");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> $onehot0({dec.found, dec.inserted, dec.bucket_full}))
      else $error("more than one outcome flagged for an item");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK || state_ff == ST_MOD))
      else $error("accepted word did not start a lookup");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished lookup did not produce a result word");

endmodule

// ===== design/bct_bucket_match.sv =====
module bct_bucket_match
   import bct_pkg::*;
#(
   parameter int WAYS = 4,
   localparam int FW = $clog2(WAYS + 1)
) (
   input  logic [WAYS-1:0][KEY_W-1:0] ent,
   input  logic [FW-1:0]              fill,
   input  logic [KEY_W-1:0]           key,
   input  logic                       kind,
   output rsp_type                    dec,
   output logic [WAYS-1:0][KEY_W-1:0] new_ent,
   output logic [FW-1:0]              new_fill
);

   logic alive;
   logic hit;
   logic room;

   always_comb begin
      alive = 1'b1;
      hit   = 1'b0;
      // scan in way order; an empty way stops the search
      for (int w = 0; w < WAYS; w++) begin
         if (alive && ent[w] == key) hit = 1'b1;
         if (ent[w] == '0) alive = 1'b0;
      end
      room = fill < FW'(WAYS);

      new_ent = ent;
      for (int w = 0; w < WAYS; w++) begin
         if (fill == FW'(w)) new_ent[w] = key;
      end
      new_fill = fill + FW'(1);

      dec.found       = hit;
      dec.inserted    = (kind == KIND_LAN) && !hit && room;
      dec.bucket_full = (kind == KIND_LAN) && !hit && !room;
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench
   import bct_pkg::*;
();

   localparam int BUCKET_COUNT = 16384;
   localparam int WAY_COUNT    = 4;
   localparam logic [KEY_W-1:0] BUCKET_MASK = 32'h3fff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predicted connection table
   logic [KEY_W-1:0] conn_entries [BUCKET_COUNT*WAY_COUNT];
   int unsigned      way_fill [BUCKET_COUNT];

   rsp_type          expected_verdicts [$];
   logic [KEY_W-1:0] recent_keys [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int words_sent    = 0;
   int verdicts_seen = 0;
   int found_count   = 0;
   int insert_count  = 0;
   int full_count    = 0;

   bucketed_connection_table #(
      .BUCKETS (BUCKET_COUNT),
      .WAYS    (WAY_COUNT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Scan the bucket in way order, then insert a missing LAN key at the fill count.
   function automatic rsp_type predict_verdict(input req_type word);
      rsp_type          verdict;
      int unsigned      bucket;
      int unsigned      fill;
      logic [KEY_W-1:0] entry;
      bit               hit;
      bucket = word.flow_hash & BUCKET_MASK;
      hit = 1'b0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         entry = conn_entries[bucket*WAY_COUNT + w];
         if (entry == word.flow_hash) begin
            hit = 1'b1;
            break;
         end
         if (entry == '0) break;
      end
      verdict = '0;
      verdict.found = hit;
      if (word.kind == KIND_LAN && !hit) begin
         fill = way_fill[bucket];
         if (fill < WAY_COUNT) begin
            conn_entries[bucket*WAY_COUNT + fill] = word.flow_hash;
            way_fill[bucket] = fill + 1;
            verdict.inserted = 1'b1;
         end else begin
            verdict.bucket_full = 1'b1;
         end
      end
      return verdict;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic kind, input logic [KEY_W-1:0] flow_hash);
      req_type word;
      rsp_type verdict;
      word.kind = kind;
      word.flow_hash = flow_hash;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (req_stall);
      verdict = predict_verdict(word);
      expected_verdicts.push_back(verdict);
      found_count  += verdict.found;
      insert_count += verdict.inserted;
      full_count   += verdict.bucket_full;
      words_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result %b, none pending", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            verdicts_seen++;
            if (rsp_data.found !== want.found) begin
               $display("%0t: found expected %b actual %b", $time, want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.inserted !== want.inserted) begin
               $display("%0t: inserted expected %b actual %b",
                        $time, want.inserted, rsp_data.inserted);
               error_count++;
            end
            if (rsp_data.bucket_full !== want.bucket_full) begin
               $display("%0t: bucket_full expected %b actual %b",
                        $time, want.bucket_full, rsp_data.bucket_full);
               error_count++;
            end
         end
      end
   end

   task automatic test_extreme_keys();
      send_word(KIND_LAN, 32'hffff_ffff);
      send_word(KIND_WAN, 32'hffff_ffff);
      send_word(KIND_WAN, 32'h7fff_ffff);
      send_word(KIND_LAN, 32'hffff_ffff);
      send_word(KIND_LAN, 32'h8000_0000);
      send_word(KIND_WAN, 32'h0000_3fff);
   endtask

   // Bucket 0 holds one key here, so a zero hash meets an empty way.
   task automatic test_zero_hash();
      send_word(KIND_WAN, 32'h0000_0000);
      send_word(KIND_LAN, 32'h0000_0000);
      send_word(KIND_WAN, 32'h8000_0000);
   endtask

   // Fill bucket 0, then probe with new, known and zero keys.
   task automatic test_full_bucket();
      send_word(KIND_LAN, 32'h0000_4000);
      send_word(KIND_LAN, 32'h0000_8000);
      send_word(KIND_LAN, 32'h0000_c000);
      send_word(KIND_LAN, 32'h1234_0000);
      send_word(KIND_LAN, 32'h0000_8000);
      send_word(KIND_WAN, 32'h1234_0000);
      send_word(KIND_LAN, 32'h0000_0000);
      send_word(KIND_WAN, 32'h0000_0000);
      send_word(KIND_WAN, 32'h0000_c000);
   endtask

   // Mostly keys aimed at a few hot buckets, with repeats so they hit and fill up.
   task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                      input int count);
      int unsigned      hot [16];
      int unsigned      pick;
      logic             kind;
      logic [KEY_W-1:0] flow_hash;
      send_idle_pct = sender_idle;
      stall_pct     = receiver_idle;
      foreach (hot[i]) hot[i] = $urandom_range(BUCKET_COUNT - 1);
      hot[0] = 0;
      repeat (count) begin
         pick = $urandom_range(99);
         kind = ($urandom_range(99) < 60) ? KIND_LAN : KIND_WAN;
         if (pick < 30 && recent_keys.size() > 0)
            flow_hash = recent_keys[$urandom_range(recent_keys.size() - 1)];
         else if (pick < 85)
            flow_hash = ($urandom() & ~BUCKET_MASK) | hot[$urandom_range(15)];
         else if (pick < 95)
            flow_hash = $urandom();
         else
            flow_hash = '0;
         recent_keys.push_back(flow_hash);
         if (recent_keys.size() > 128) void'(recent_keys.pop_front());
         send_word(kind, flow_hash);
      end
   endtask

   initial begin
      foreach (conn_entries[i]) conn_entries[i] = '0;
      foreach (way_fill[i]) way_fill[i] = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 38;
      stall_pct     = 45;
      test_extreme_keys();
      test_zero_hash();
      test_full_bucket();
      test_random_traffic(38, 45, 400);
      test_random_traffic(45, 38, 400);
      test_random_traffic(0, 0, 400);

      req_valid <= 1'b0;
      stall_pct = 0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d words sent and %0d results checked", words_sent, verdicts_seen);
      $display("lookups found %0d, inserts %0d, bucket full %0d, under three idle mixes",
               found_count, insert_count, full_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // covers the clearing pass after reset plus the slowest idle mix, many times over
   initial begin
      #10_000_000;
      $display("Timeout with %0d results pending", expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
design/bct_pkg.sv
design/bct_bucket_match.sv
design/bucketed_connection_table.sv
tb/sv/testbench.sv
